// ===== rtl/stereo_chorus_delay_line_core_macros.svh =====
// Assertion macros for the stereo chorus delay line core.
// Included by files that check their own logic; needs nothing else.
`ifndef STEREO_CHORUS_DELAY_LINE_CORE_MACROS_SVH
`define STEREO_CHORUS_DELAY_LINE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scd_pkg.sv =====
// Shared types, constants and the sine table builder of the stereo chorus core.
// Depends on nothing; imported by the core.
package scd_pkg;

    localparam int LINE_LEN        = 2048;
    localparam int SINE_ENTRIES    = 2048;
    localparam int DELAY_FRAC_BITS = 8;

    localparam int LINE_BITS  = $clog2(LINE_LEN);
    localparam int SINE_BITS  = $clog2(SINE_ENTRIES);
    localparam int POS_W      = LINE_BITS + DELAY_FRAC_BITS;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 15;
    localparam int DELAY_W    = 11;
    localparam int PHASE_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LEVEL   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MIX    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THROUGH_GAIN  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SAMPLES = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET  = 8'd6;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] dry_sample;
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRY,
        S_STORE,
        S_DQ_L,
        S_DQ_R,
        S_RD_LB,
        S_MUL_L,
        S_IV_L,
        S_MIX_L,
        S_ACC_L,
        S_OUT_L,
        S_THRU_R,
        S_ACC_R,
        S_DONE
    } state_t;

    typedef logic signed [SAMPLE_W-1:0] sine_rom_t [SINE_ENTRIES];

    // Sine of a 32-bit turn: quadrant folding, Q30 Taylor series up to the
    // x^13 term with truncating products, then rounding to Q15.
    function automatic logic signed [SAMPLE_W-1:0] sine_of_turn(input logic [31:0] t);
        logic [1:0]         quad;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [SAMPLE_W-1:0] mag;
        quad = t[31:30];
        r    = {34'd0, t[29:0]};
        if (quad[0]) begin
            r = 64'h0000_0000_4000_0000 - r;
        end
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 64'sd0) begin
            sum = 64'sd0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd32767) begin
            sum = 64'sd32767;
        end
        mag = sum[SAMPLE_W-1:0];
        return quad[1] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [31:0] turn;
        for (int n = 0; n < SINE_ENTRIES; n++) begin
            turn   = 32'(n) << (32 - SINE_BITS);
            rom[n] = sine_of_turn(turn);
        end
        return rom;
    endfunction

endpackage

// ===== rtl/stereo_chorus_delay_line_core.sv =====
// Stereo chorus core: LFO-modulated two-tap delay line with one shared multiplier.
// Depends on scd_pkg and on stereo_chorus_delay_line_core_macros.svh.
//
// Each accepted item carries a mono sample and the current left and right
// samples. The mono sample is scaled by input_level and written into a
// circular delay line; two taps, driven by a sine oscillator and the same
// oscillator shifted by phase_offset, read the line with fractional delay
// and linear interpolation, and each output is the through-scaled channel
// minus the output_mix-scaled wet tap, rounded half up and saturated. Items
// are worked on one at a time: nine products share the single registered
// multiplier and four interpolation reads share the single read port of
// the delay memory, under a sequencer of 13 states plus the idle state.
// The result is held in an output register, so the next item is accepted
// while a result still waits; only the last state stalls if the previous
// result has not been taken yet. The sine table is fixed. The delay line
// needs no clearing pass after reset: the write pointer and a wrap flag
// tell which entries were written, and entries never written read as
// zero. Configuration writes are taken in any cycle and must only be
// issued while no item is in flight.
`include "stereo_chorus_delay_line_core_macros.svh"

module stereo_chorus_delay_line_core
    import scd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Datapath widths. The interpolated tap carries DELAY_FRAC_BITS extra
    // fraction bits; the accumulator holds through term and wet term.
    localparam int F          = DELAY_FRAC_BITS;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int IV_W       = SAMPLE_W + F + 1;
    localparam int MA_W       = IV_W;
    localparam int MB_W       = SAMPLE_W + 2;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int HALF_SCALE = 1 << (SAMPLE_W - 1);
    localparam int OUT_SHIFT  = 14 + F;
    localparam int STORE_SH   = 15;

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Configuration registers.
    logic [GAIN_W-1:0]  input_level_reg;
    logic [GAIN_W-1:0]  output_mix_reg;
    logic [GAIN_W-1:0]  through_gain_reg;
    logic [DELAY_W-1:0] depth_samples_reg;
    logic [DELAY_W-1:0] base_delay_reg;
    logic [PHASE_W-1:0] lfo_step_reg;
    logic [PHASE_W-1:0] phase_offset_reg;

    // Control state.
    state_t               state_reg;
    state_t               state_next;
    logic [PHASE_W-1:0]   phase_reg;
    logic [LINE_BITS-1:0] wp_reg;
    logic                 filled_reg;
    logic                 m_valid_reg;

    // Payload registers.
    in_item_t                   item_reg;
    out_item_t                  m_data_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] rom_q_reg;
    logic signed [SAMPLE_W-1:0] mem_q_reg;
    logic                       rd_valid_reg;
    logic [POS_W-1:0]           pos_l_reg;
    logic [POS_W-1:0]           pos_r_reg;
    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [SAMPLE_W-1:0] b_reg;
    logic signed [IV_W-1:0]     iv_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] left_res_reg;

    // The delay line memory: one write port, one registered read port.
    logic signed [SAMPLE_W-1:0] delay_mem [LINE_LEN];

    // Sequencer outputs.
    logic                       mem_we;
    logic                       rom_sel_right;
    logic [LINE_BITS-1:0]       rd_addr;
    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;

    // Combinational datapath.
    logic                       in_accept;
    logic                       out_load;
    logic [PHASE_W-1:0]         phase_right;
    logic [SINE_BITS-1:0]       rom_addr;
    logic signed [SAMPLE_W-1:0] q_masked;
    logic signed [SAMPLE_W-1:0] stored_sample;
    logic [DIFF_W-1:0]          depth_factor;
    logic signed [SAMPLE_W-1:0] b_sel;
    logic signed [DIFF_W-1:0]   tap_diff;
    logic [F-1:0]               frac_sel;
    logic [POS_W-1:0]           tap_pos;
    logic signed [IV_W-1:0]     iv_next;
    logic signed [ACC_W-1:0]    thru_term;
    logic signed [ACC_W-1:0]    mix_term;
    logic signed [SAMPLE_W-1:0] out_round;

    // Rounds half up by 2^sh and saturates to one sample.
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] v,
        input int                      sh
    );
        logic signed [ACC_W-1:0] t;
        t = (v + (ACC_W'(1) <<< (sh - 1))) >>> sh;
        if (t > ACC_W'(32767)) begin
            return SAMPLE_W'(32767);
        end else if (t < ACC_W'(-32768)) begin
            return SAMPLE_W'(-32768);
        end
        return t[SAMPLE_W-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign in_accept = s_valid && s_ready;
    assign out_load  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // The right oscillator is the left phase plus the fixed offset; the table
    // index is the top bits of the phase.
    assign phase_right = phase_reg + phase_offset_reg;
    assign rom_addr    = rom_sel_right ? phase_right[PHASE_W-1 -: SINE_BITS]
                                       : phase_reg[PHASE_W-1 -: SINE_BITS];

    // Entries that were never written read as zero.
    assign q_masked = rd_valid_reg ? mem_q_reg : '0;

    assign stored_sample = round_sat(ACC_W'(prod_reg), STORE_SH);
    assign depth_factor  = DIFF_W'(HALF_SCALE) - DIFF_W'(rom_q_reg);

    // Read position: write pointer minus base delay minus modulated delay,
    // all in fixed point with F fraction bits, wrapping with the line.
    assign tap_pos = (POS_W'(wp_reg) << F) - (POS_W'(base_delay_reg) << F)
                   - POS_W'(prod_reg >>> (SAMPLE_W - F));

    // The left tap takes its upper sample straight from the read port; the
    // right tap finds it parked in b_reg.
    assign b_sel    = (state_reg == S_MUL_L) ? q_masked : b_reg;
    assign frac_sel = (state_reg == S_MUL_L) ? pos_l_reg[F-1:0] : pos_r_reg[F-1:0];

    // a*(1-f) + b*f is formed as a*2^F + (b-a)*f, one product per tap.
    assign tap_diff  = DIFF_W'(b_sel) - DIFF_W'(a_reg);
    assign iv_next   = (IV_W'(a_reg) <<< F) + IV_W'(prod_reg);
    assign thru_term = ACC_W'(prod_reg) <<< F;
    assign mix_term  = ACC_W'(prod_reg) <<< 1;
    assign out_round = round_sat(acc_reg, OUT_SHIFT);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DRY;
                end
            end
            S_DRY:    state_next = S_STORE;
            S_STORE:  state_next = S_DQ_L;
            S_DQ_L:   state_next = S_DQ_R;
            S_DQ_R:   state_next = S_RD_LB;
            S_RD_LB:  state_next = S_MUL_L;
            S_MUL_L:  state_next = S_IV_L;
            S_IV_L:   state_next = S_MIX_L;
            S_MIX_L:  state_next = S_ACC_L;
            S_ACC_L:  state_next = S_OUT_L;
            S_OUT_L:  state_next = S_THRU_R;
            S_THRU_R: state_next = S_ACC_R;
            S_ACC_R:  state_next = S_DONE;
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands, memory and table addresses.
    always_comb begin
        s_ready       = 1'b0;
        mem_we        = 1'b0;
        rom_sel_right = 1'b0;
        rd_addr       = pos_l_reg[POS_W-1 -: LINE_BITS];
        mul_a         = '0;
        mul_b         = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_DRY: begin
                mul_a = MA_W'(item_reg.dry_sample);
                mul_b = MB_W'(input_level_reg);
            end
            S_STORE: begin
                mem_we        = 1'b1;
                rom_sel_right = 1'b1;
                mul_a         = MA_W'(depth_samples_reg);
                mul_b         = MB_W'(depth_factor);
            end
            S_DQ_L: begin
                mul_a = MA_W'(depth_samples_reg);
                mul_b = MB_W'(depth_factor);
            end
            S_DQ_R: begin
                rd_addr = pos_l_reg[POS_W-1 -: LINE_BITS];
                mul_a   = MA_W'(item_reg.left_in);
                mul_b   = MB_W'(through_gain_reg);
            end
            S_RD_LB: begin
                rd_addr = pos_l_reg[POS_W-1 -: LINE_BITS] + LINE_BITS'(1);
            end
            S_MUL_L: begin
                rd_addr = pos_r_reg[POS_W-1 -: LINE_BITS];
                mul_a   = MA_W'(tap_diff);
                mul_b   = MB_W'(frac_sel);
            end
            S_IV_L: begin
                rd_addr = pos_r_reg[POS_W-1 -: LINE_BITS] + LINE_BITS'(1);
            end
            S_MIX_L: begin
                mul_a = iv_reg;
                mul_b = MB_W'(output_mix_reg);
            end
            S_ACC_L: begin
                mul_a = MA_W'(tap_diff);
                mul_b = MB_W'(frac_sel);
            end
            S_OUT_L: begin
                mul_a = MA_W'(item_reg.right_in);
                mul_b = MB_W'(through_gain_reg);
            end
            S_THRU_R: begin
                mul_a = iv_reg;
                mul_b = MB_W'(output_mix_reg);
            end
            S_ACC_R: begin
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_level_reg   <= GAIN_W'(16384);
            output_mix_reg    <= '0;
            through_gain_reg  <= GAIN_W'(16384);
            depth_samples_reg <= '0;
            base_delay_reg    <= '0;
            lfo_step_reg      <= '0;
            phase_offset_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_INPUT_LEVEL:   input_level_reg   <= cfg_data[GAIN_W-1:0];
                CFG_OUTPUT_MIX:    output_mix_reg    <= cfg_data[GAIN_W-1:0];
                CFG_THROUGH_GAIN:  through_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_DEPTH_SAMPLES: depth_samples_reg <= cfg_data[DELAY_W-1:0];
                CFG_BASE_DELAY:    base_delay_reg    <= cfg_data[DELAY_W-1:0];
                CFG_LFO_STEP:      lfo_step_reg      <= cfg_data[PHASE_W-1:0];
                CFG_PHASE_OFFSET:  phase_offset_reg  <= cfg_data[PHASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control state: sequencer, oscillator phase, write pointer, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= '0;
            wp_reg      <= '0;
            filled_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_accept) begin
                phase_reg <= phase_reg + lfo_step_reg;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
                wp_reg      <= wp_reg + LINE_BITS'(1);
                // Once the pointer wraps, every entry holds a written sample.
                if (wp_reg == LINE_BITS'(LINE_LEN - 1)) begin
                    filled_reg <= 1'b1;
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Shared multiplier, sine table and delay memory.
    always_ff @(posedge aclk) begin
        prod_reg     <= mul_a * mul_b;
        rom_q_reg    <= SINE_ROM[rom_addr];
        if (mem_we) begin
            delay_mem[wp_reg] <= stored_sample;
        end
        mem_q_reg    <= delay_mem[rd_addr];
        rd_valid_reg <= filled_reg || (rd_addr <= wp_reg);
    end

    // Datapath registers loaded by the sequencer.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            item_reg <= s_data;
        end
        if (out_load) begin
            m_data_reg.left_out  <= left_res_reg;
            m_data_reg.right_out <= out_round;
        end
        unique case (state_reg)
            S_DQ_L: begin
                pos_l_reg <= tap_pos;
            end
            S_DQ_R: begin
                pos_r_reg <= tap_pos;
            end
            S_RD_LB: begin
                a_reg   <= q_masked;
                acc_reg <= thru_term;
            end
            S_IV_L: begin
                iv_reg <= iv_next;
                a_reg  <= q_masked;
            end
            S_MIX_L: begin
                b_reg <= q_masked;
            end
            S_ACC_L: begin
                acc_reg <= acc_reg - mix_term;
            end
            S_OUT_L: begin
                left_res_reg <= out_round;
                iv_reg       <= iv_next;
            end
            S_THRU_R: begin
                acc_reg <= thru_term;
            end
            S_ACC_R: begin
                acc_reg <= acc_reg - mix_term;
            end
            default: begin
            end
        endcase
    end

    // An accepted item occupies the block, so the next cycle is not ready.
    `SCD_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, in_accept, !s_ready, "ready after accept")

    // The oscillator advances by exactly one step per accepted item.
    `SCD_ASSERT_NEXT(a_phase_step, aclk, aresetn, in_accept, phase_reg == $past(phase_reg) + $past(lfo_step_reg), "phase step wrong")

    // The write pointer stays put while an item is being worked on.
    `SCD_ASSERT_NEXT(a_wp_hold, aclk, aresetn, (state_reg != S_IDLE) && (state_reg != S_DONE), $stable(wp_reg), "write pointer moved mid item")

    // The wrap flag never clears outside reset.
    `SCD_ASSERT_NEXT(a_filled_sticky, aclk, aresetn, filled_reg, filled_reg, "wrap flag cleared")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the stereo chorus delay line core.
// Depends on scd_pkg and on the core; holds its own model of the chorus arithmetic.
`timescale 1ns / 1ps

module testbench;
    import scd_pkg::*;

    // The run is stopped as failed if it is still going after this many cycles.
    localparam int RUN_LIMIT = 300000;
    // Cycles the block may still need after the last result before a register write.
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS = 550;
    localparam int MAX_WAIT = 14;
    // Register indexes from this one upward select no register at all.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 8'd7;
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    stereo_chorus_delay_line_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    int cycle_count = 0;
    int n_errors = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Chorus model: its own copy of the registers, the delay line, the
    // write pointer, the oscillator phase and the sine table.
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]          lvl_in;
    logic [GAIN_W-1:0]          mix_gain;
    logic [GAIN_W-1:0]          thru_gain;
    logic [DELAY_W-1:0]         mod_depth;
    logic [DELAY_W-1:0]         fixed_delay;
    logic [PHASE_W-1:0]         lfo_inc;
    logic [PHASE_W-1:0]         right_phase_off;

    logic signed [SAMPLE_W-1:0] line_mem [LINE_LEN];
    logic [LINE_BITS-1:0]       wr_ptr;
    logic [PHASE_W-1:0]         lfo_acc;
    logic signed [SAMPLE_W-1:0] sine_tab [SINE_ENTRIES];

    // Sine of a 32-bit turn in Q1.15. The turn is folded into the first
    // quadrant, mapped to radians in Q30 and fed to a Taylor series that
    // stops at the x^13 term; every product truncates.
    function automatic logic signed [SAMPLE_W-1:0] sine_q15(input logic [31:0] turn);
        logic [1:0]                 quad;
        longint unsigned            r;
        longint unsigned            x;
        longint unsigned            x2;
        longint unsigned            term;
        longint                     acc;
        logic signed [SAMPLE_W-1:0] mag;
        quad = turn[31:30];
        r = turn[29:0];
        if (quad[0]) begin
            r = (64'd1 << 30) - r;
        end
        x = (r * QUARTER_TURN_Q30) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / longint'(2 * k * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + 16384) >>> 15;
        if (acc > 32767) begin
            acc = 32767;
        end
        mag = acc[SAMPLE_W-1:0];
        return quad[1] ? -mag : mag;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_q15(input longint v);
        if (v > 32767) begin
            return Q15_MAX;
        end
        if (v < -32768) begin
            return Q15_MIN;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // Interpolated tap of the delay line for one oscillator phase, scaled by
    // 2^DELAY_FRAC_BITS. A total delay at or past the line length wraps.
    function automatic longint tap_read(input logic [PHASE_W-1:0] phase);
        longint s;
        longint dq;
        longint span;
        longint d;
        longint p;
        longint i;
        longint f;
        longint a;
        longint b;
        s = sine_tab[phase >> (PHASE_W - SINE_BITS)];
        span = longint'(LINE_LEN) << DELAY_FRAC_BITS;
        dq = (longint'(mod_depth) * (32768 - s)) >>> (16 - DELAY_FRAC_BITS);
        d = ((longint'(fixed_delay) << DELAY_FRAC_BITS) + dq) % span;
        p = ((longint'(wr_ptr) << DELAY_FRAC_BITS) + span - d) % span;
        i = p >>> DELAY_FRAC_BITS;
        f = p % (longint'(1) << DELAY_FRAC_BITS);
        a = line_mem[i];
        b = line_mem[(i + 1) % LINE_LEN];
        return a * ((longint'(1) << DELAY_FRAC_BITS) - f) + b * f;
    endfunction

    // Through-scaled channel minus the mixed wet tap, rounded half up.
    function automatic logic signed [SAMPLE_W-1:0] wet_mix(input logic signed [SAMPLE_W-1:0] x,
                                                           input longint iv);
        longint acc;
        acc = longint'(x) * longint'(thru_gain) * (longint'(1) << DELAY_FRAC_BITS)
              - 2 * iv * longint'(mix_gain);
        return sat_q15((acc + (longint'(1) << (13 + DELAY_FRAC_BITS)))
                       >>> (14 + DELAY_FRAC_BITS));
    endfunction

    // One sample period: advance the oscillator, store the scaled sample,
    // read both taps (the newest sample is already in the line), mix.
    function automatic out_item_t chorus_step(input in_item_t item);
        longint    prod;
        longint    ivl;
        longint    ivr;
        out_item_t res;
        lfo_acc = lfo_acc + lfo_inc;
        prod = longint'($signed(item.dry_sample)) * longint'(lvl_in);
        line_mem[wr_ptr] = sat_q15((prod + 16384) >>> 15);
        ivl = tap_read(lfo_acc);
        ivr = tap_read(lfo_acc + right_phase_off);
        res.left_out = wet_mix($signed(item.left_in), ivl);
        res.right_out = wet_mix($signed(item.right_in), ivr);
        wr_ptr = wr_ptr + 1'b1;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Queues shared by the stimulus, the drivers and the monitor.
    // ------------------------------------------------------------------
    in_item_t   samples_to_send [$];
    out_item_t  predicted_outs [$];
    reg_write_t reg_writes [$];
    // When set, neither side idles, so items go back to back.
    bit         no_gaps = 1'b0;

    // Sample driver. The model is advanced at the very edge at which an item
    // is taken, so the predicted outputs queue up in acceptance order. After
    // each item it draws an idle gap; with no gap and another item waiting,
    // valid simply stays high and only the payload changes.
    int send_gap = 0;

    always @(posedge aclk) begin
        int gap;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (s_valid && s_ready) begin
            predicted_outs.push_back(chorus_step(s_data));
            gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap == 0 && samples_to_send.size() != 0) begin
                s_data <= samples_to_send.pop_front();
            end else begin
                s_valid <= 1'b0;
                send_gap <= gap;
            end
        end else if (!s_valid) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
            end else if (samples_to_send.size() != 0) begin
                s_valid <= 1'b1;
                s_data <= samples_to_send.pop_front();
            end
        end
    end

    // Register write driver. Writes leave back to back; the model copy of a
    // register changes at the edge the write is taken, masked to its width.
    // An index that selects no register leaves the model untouched.
    always @(posedge aclk) begin
        reg_write_t w;
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_INPUT_LEVEL:   lvl_in = cfg_data[GAIN_W-1:0];
                    CFG_OUTPUT_MIX:    mix_gain = cfg_data[GAIN_W-1:0];
                    CFG_THROUGH_GAIN:  thru_gain = cfg_data[GAIN_W-1:0];
                    CFG_DEPTH_SAMPLES: mod_depth = cfg_data[DELAY_W-1:0];
                    CFG_BASE_DELAY:    fixed_delay = cfg_data[DELAY_W-1:0];
                    CFG_LFO_STEP:      lfo_inc = cfg_data;
                    CFG_PHASE_OFFSET:  right_phase_off = cfg_data;
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_writes.size() != 0) begin
                    w = reg_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.idx;
                    cfg_data <= w.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each result taken is checked against the oldest
    // prediction; then the receiver draws how long it stalls before the
    // next one.
    int take_gap = 0;

    always @(posedge aclk) begin
        int        gap;
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            take_gap <= 0;
        end else if (m_valid && m_ready) begin
            if (predicted_outs.size() == 0) begin
                $error("result item with no prediction waiting: left_out %0d, right_out %0d",
                       $signed(m_data.left_out), $signed(m_data.right_out));
                n_errors++;
            end else begin
                want = predicted_outs.pop_front();
                if (m_data.left_out !== want.left_out) begin
                    $error("left_out mismatch: expected %0d, actual %0d",
                           $signed(want.left_out), $signed(m_data.left_out));
                    n_errors++;
                end
                if (m_data.right_out !== want.right_out) begin
                    $error("right_out mismatch: expected %0d, actual %0d",
                           $signed(want.right_out), $signed(m_data.right_out));
                    n_errors++;
                end
            end
            gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap != 0) begin
                m_ready <= 1'b0;
                take_gap <= gap;
            end
        end else if (!m_ready) begin
            if (take_gap <= 1) begin
                m_ready <= 1'b1;
                take_gap <= 0;
            end else begin
                take_gap <= take_gap - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    // Returns at a falling edge once every item has been sent and every
    // predicted result has been taken.
    task automatic wait_drained();
        @(negedge aclk);
        while (samples_to_send.size() != 0 || s_valid || predicted_outs.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Sets random bits above a register's width half of the time; the block
    // must drop them.
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                        input int width);
        if ($urandom_range(0, 1) == 1) begin
            return v | ($urandom() << width);
        end
        return v;
    endfunction

    // Writes all seven registers while the block is idle. A write to an index
    // that selects no register is mixed in now and then, or always if stray
    // is set.
    task automatic set_regs(input logic [GAIN_W-1:0] il, input logic [GAIN_W-1:0] om,
                            input logic [GAIN_W-1:0] tg, input logic [DELAY_W-1:0] dep,
                            input logic [DELAY_W-1:0] bd, input logic [PHASE_W-1:0] inc,
                            input logic [PHASE_W-1:0] off, input bit stray);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (stray || $urandom_range(0, 3) == 0) begin
            reg_writes.push_back(reg_write_t'{idx: $urandom_range(CFG_FIRST_UNUSED, 255),
                                              data: $urandom()});
        end
        reg_writes.push_back(reg_write_t'{idx: CFG_INPUT_LEVEL, data: with_junk(il, GAIN_W)});
        reg_writes.push_back(reg_write_t'{idx: CFG_OUTPUT_MIX, data: with_junk(om, GAIN_W)});
        reg_writes.push_back(reg_write_t'{idx: CFG_THROUGH_GAIN, data: with_junk(tg, GAIN_W)});
        reg_writes.push_back(reg_write_t'{idx: CFG_DEPTH_SAMPLES,
                                          data: with_junk(dep, DELAY_W)});
        reg_writes.push_back(reg_write_t'{idx: CFG_BASE_DELAY, data: with_junk(bd, DELAY_W)});
        reg_writes.push_back(reg_write_t'{idx: CFG_LFO_STEP, data: inc});
        reg_writes.push_back(reg_write_t'{idx: CFG_PHASE_OFFSET, data: off});
        if (stray) begin
            reg_writes.push_back(reg_write_t'{idx: CFG_FIRST_UNUSED, data: $urandom()});
        end
        while (reg_writes.size() != 0 || cfg_valid) begin
            @(negedge aclk);
        end
    endtask

    function automatic void queue_sample(input logic signed [SAMPLE_W-1:0] dry,
                                         input logic signed [SAMPLE_W-1:0] l,
                                         input logic signed [SAMPLE_W-1:0] r);
        samples_to_send.push_back(in_item_t'{dry, l, r});
    endfunction

    // Random sample that lands on a full-scale value or zero now and then.
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return Q15_MAX;
            1: return Q15_MIN;
            2: return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom_range(0, 32767);
        endcase
    endfunction

    initial begin
        int                 n_random;
        int                 len;
        bit                 first_phase;
        logic [DELAY_W-1:0] dep;
        logic [DELAY_W-1:0] bd;
        logic [PHASE_W-1:0] inc;

        // The model starts where the block starts after reset.
        for (int n = 0; n < SINE_ENTRIES; n++) begin
            sine_tab[n] = sine_q15(32'(n) << (PHASE_W - SINE_BITS));
        end
        for (int n = 0; n < LINE_LEN; n++) begin
            line_mem[n] = '0;
        end
        wr_ptr = '0;
        lfo_acc = '0;
        lvl_in = 15'd16384;
        mix_gain = '0;
        thru_gain = 15'd16384;
        mod_depth = '0;
        fixed_delay = '0;
        lfo_inc = '0;
        right_phase_off = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // With the reset settings the wet mix is zero and the through gain is
        // unity, so each output is its channel input.
        queue_sample(Q15_MAX, Q15_MAX, Q15_MIN);
        queue_sample(Q15_MIN, Q15_MIN, Q15_MAX);
        queue_sample('0, '0, '0);
        queue_sample(-16'sd1, -16'sd1, 16'sd1);

        // Zero delay: both taps read the sample stored in the same period.
        // Full-scale gains drive the outputs into saturation both ways.
        set_regs('1, '1, '1, '0, '0, '0, '0, 1'b0);
        queue_sample(Q15_MAX, Q15_MAX, Q15_MAX);
        queue_sample(Q15_MIN, Q15_MIN, Q15_MIN);
        queue_sample(Q15_MAX, Q15_MIN, Q15_MAX);
        queue_sample(Q15_MIN, Q15_MAX, '0);
        queue_sample(16'sd1, -16'sd1, '0);

        // Depth plus base delay far past the line length, so the read
        // position wraps; stray writes to unused indexes go alongside.
        set_regs(15'd16384, 15'd16384, '0, '1, '1, '1, 32'h8000_0000, 1'b1);
        for (int j = 0; j < 6; j++) begin
            queue_sample(rand_sample(), rand_sample(), rand_sample());
        end

        // Nothing new is stored, but the taps still see earlier samples.
        set_regs('0, '1, 15'd16384, '1, '0, 32'h8000_0000, '1, 1'b0);
        for (int j = 0; j < 4; j++) begin
            queue_sample(rand_sample(), rand_sample(), rand_sample());
        end

        // Random settings, each held for a run of items. Most runs keep the
        // delays short enough to read back what was stored recently, which is
        // where the interpolation does real work.
        n_random = 0;
        first_phase = 1'b1;
        while (n_random < RANDOM_ITEMS) begin
            dep = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 200);
            bd = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 400);
            case ($urandom_range(0, 4))
                0: inc = '0;
                1: inc = $urandom_range(0, 1 << 24);
                2: inc = $urandom_range(0, 1 << 28);
                3: inc = '1;
                default: inc = $urandom();
            endcase
            set_regs(rand_gain(), rand_gain(), rand_gain(), dep, bd, inc, $urandom(), 1'b0);
            no_gaps = ($urandom_range(0, 3) == 0);
            len = $urandom_range(20, 70);
            for (int j = 0; j < len; j++) begin
                // Halfway through some runs the sender holds back until every
                // result so far has come out, which leaves the block empty.
                if (j == len / 2 && (first_phase || $urandom_range(0, 2) == 0)) begin
                    wait_drained();
                end
                queue_sample(rand_sample(), rand_sample(), rand_sample());
            end
            n_random += len;
            first_phase = 1'b0;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (n_errors == 0) begin
            $display("** stereo_chorus_delay_line_core: PASSED **");
        end else begin
            $display("** stereo_chorus_delay_line_core: FAILED **");
        end
        $finish;
    end

    // A hung handshake or a lost result ends the run here.
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("** stereo_chorus_delay_line_core: FAILED **");
        $finish;
    end

endmodule
